// File: sv/affine_vector_iteration_macros.svh
// Assertion macros shared by the affine vector iteration RTL.
`ifndef AFFINE_VECTOR_ITERATION_MACROS_SVH
`define AFFINE_VECTOR_ITERATION_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define AVI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("affine_vector_iteration: implication check failed");

// Next-cycle implication, checked while out of reset.
`define AVI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("affine_vector_iteration: next-cycle check failed");

`endif

// File: sv/avi_pkg.sv
// Package with Q16.16 types, widths and saturation helpers for the affine vector iteration.
package avi_pkg;

	localparam int Q_W             = 32;
	localparam int FRAC_W          = 16;
	localparam int PROD_W          = 2 * Q_W;
	localparam int ROW_IDX_W       = 3;
	localparam int VECTOR_SIZE_DEF = 8;

	typedef logic signed [Q_W-1:0]    q_t;
	typedef logic signed [Q_W:0]      q_ext_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic [ROW_IDX_W-1:0]     row_idx_t;

	localparam q_t Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
	localparam q_t Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

	// Clamps a sum that carries one guard bit to the signed Q16.16 range.
	function automatic q_t sat_sum(q_ext_t v);
		q_t r;
		if (v[Q_W] != v[Q_W-1]) begin
			r = v[Q_W] ? Q_MIN : Q_MAX;
		end else begin
			r = v[Q_W-1:0];
		end
		return r;
	endfunction

	// Floors a Q32.32 product to Q16.16 and clamps it to the signed range.
	function automatic q_t sat_prod(prod_t p);
		q_t r;
		if (p[PROD_W-1:Q_W+FRAC_W-1] == {(PROD_W-Q_W-FRAC_W+1){p[PROD_W-1]}}) begin
			r = p[Q_W+FRAC_W-1:FRAC_W];
		end else begin
			r = p[PROD_W-1] ? Q_MIN : Q_MAX;
		end
		return r;
	endfunction

endpackage

// File: sv/avi_in_if.sv
// Valid/ready channel that carries one matrix element and the row bias.
interface avi_in_if;
	import avi_pkg::*;

	logic valid;
	logic ready;
	q_t   matrix_value;
	q_t   bias_value;

	modport source (output valid, output matrix_value, output bias_value, input ready);
	modport sink (input valid, input matrix_value, input bias_value, output ready);
endinterface

// File: sv/avi_out_if.sv
// Valid/ready channel that carries one row result of the affine vector iteration.
interface avi_out_if;
	import avi_pkg::*;

	logic     valid;
	logic     ready;
	q_t       row_result;
	row_idx_t row_index;
	logic     last_row;

	modport source (output valid, output row_result, output row_index, output last_row,
		input ready);
	modport sink (input valid, input row_result, input row_index, input last_row,
		output ready);
endinterface

// File: sv/avi_vec_mem.sv
// Two-bank vector memory with one synchronous read port and one write port.
module avi_vec_mem #(
	parameter int IDX_W = 3
) (
	input  logic            clk,
	input  logic            rd_en,
	input  logic [IDX_W:0]  rd_addr,
	output avi_pkg::q_t     rd_data,
	input  logic            wr_en,
	input  logic [IDX_W:0]  wr_addr,
	input  avi_pkg::q_t     wr_data
);
	import avi_pkg::*;

	localparam int DEPTH = 2 ** (IDX_W + 1);

	q_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

// File: sv/affine_vector_iteration.sv
// Top level of the affine vector iteration x <- A*x + b in saturating Q16.16.
//
//   port        role    moves
//   matrix_ch   sink    matrix_value, bias_value (one matrix element, row-major)
//   result_ch   source  row_result, row_index, last_row (one item per finished row)
//
// One element is taken per clock while matrix_ch.ready is high; after the transfer of its row's
// last element, a result passes the multiply, accumulate and bias stages and the result queue.
// After the element that closes the whole vector, input stalls until the last
// row result is written into the bank that the next pass reads (memory write interlock).
// Up to four results may wait on a stalled result_ch before input stalls as well.
// Reset restores the vector to 0,1,2,... at once; no clearing pass is needed.
`include "affine_vector_iteration_macros.svh"

module affine_vector_iteration #(
	parameter int VECTOR_SIZE = avi_pkg::VECTOR_SIZE_DEF
) (
	input logic      clk,
	input logic      arst_n,
	avi_in_if.sink   matrix_ch,
	avi_out_if.source result_ch
);
	import avi_pkg::*;

	localparam int IDX_W      = (VECTOR_SIZE > 1) ? $clog2(VECTOR_SIZE) : 1;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = PTR_W + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VECTOR_SIZE - 1);

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		q_t       row_result;
		row_idx_t row_index;
		logic     last_row;
	} result_t;

	// Read-side position and bank selection.
	idx_t col_q;
	idx_t row_q;
	logic sel_q;
	logic init_q;

	logic accept;
	logic col_end;
	logic row_end;
	logic hazard;

	// Stage 1: memory read data arrives, multiply.
	logic v_s1, rowend_s1, last_s1, wbank_s1, init_s1;
	q_t   matrix_s1, bias_s1;
	idx_t row_s1, col_s1;
	q_t   rd_data;
	q_t   x_s1;
	prod_t prod_d;

	// Stage 2: floor, saturate and accumulate.
	logic  v_s2, rowend_s2, last_s2, wbank_s2;
	prod_t prod_s2;
	q_t    bias_s2;
	idx_t  row_s2;
	q_t    acc_q;
	q_t    psat;
	q_t    acc_next;

	// Stage 3: bias addition, write-back and result queue.
	logic v_s3, last_s3, wbank_s3;
	q_t   sum_s3, bias_s3;
	idx_t row_s3;
	q_t   result_d;

	// Result queue and occupancy of results in flight.
	result_t          fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] pend_q;
	logic             fifo_push, fifo_pop;

	assign col_end = (col_q == LAST_IDX);
	assign row_end = (row_q == LAST_IDX);

	assign hazard = (v_s1 && rowend_s1 && (wbank_s1 == sel_q))
		|| (v_s2 && rowend_s2 && (wbank_s2 == sel_q))
		|| (v_s3 && (wbank_s3 == sel_q));

	assign matrix_ch.ready = (pend_q < CNT_W'(FIFO_DEPTH)) && !hazard;
	assign accept          = matrix_ch.valid && matrix_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			sel_q  <= 1'b0;
			init_q <= 1'b1;
		end else if (accept) begin
			col_q <= col_end ? '0 : col_q + 1'b1;
			if (col_end) begin
				row_q <= row_end ? '0 : row_q + 1'b1;
				if (row_end) begin
					sel_q  <= ~sel_q;
					init_q <= 1'b0;
				end
			end
		end
	end

	avi_vec_mem #(
		.IDX_W (IDX_W)
	) u_vec_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr ({sel_q, col_q}),
		.rd_data (rd_data),
		.wr_en   (v_s3),
		.wr_addr ({wbank_s3, row_s3}),
		.wr_data (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && rowend_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			matrix_s1 <= matrix_ch.matrix_value;
			bias_s1   <= matrix_ch.bias_value;
			rowend_s1 <= col_end;
			last_s1   <= row_end;
			row_s1    <= row_q;
			col_s1    <= col_q;
			wbank_s1  <= ~sel_q;
			init_s1   <= init_q;
		end
	end

	// During the first pass the vector is taken as its reset value, entry i equal to i, not read from memory.
	assign x_s1   = init_s1 ? (Q_W'(col_s1) << FRAC_W) : rd_data;
	assign prod_d = matrix_s1 * x_s1;

	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_s2   <= prod_d;
			bias_s2   <= bias_s1;
			rowend_s2 <= rowend_s1;
			last_s2   <= last_s1;
			row_s2    <= row_s1;
			wbank_s2  <= wbank_s1;
		end
	end

	assign psat     = sat_prod(prod_s2);
	assign acc_next = sat_sum(q_ext_t'(acc_q) + q_ext_t'(psat));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= rowend_s2 ? '0 : acc_next;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && rowend_s2) begin
			sum_s3   <= acc_next;
			bias_s3  <= bias_s2;
			last_s3  <= last_s2;
			row_s3   <= row_s2;
			wbank_s3 <= wbank_s2;
		end
	end

	assign result_d = sat_sum(q_ext_t'(sum_s3) + q_ext_t'(bias_s3));

	assign fifo_push = v_s3;
	assign fifo_pop  = result_ch.valid && result_ch.ready;

	always_ff @(posedge clk) begin
		if (fifo_push) begin
			fifo_q[tail_q] <= '{row_result: result_d, row_index: ROW_IDX_W'(row_s3),
				last_row: last_s3};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
			pend_q <= '0;
		end else begin
			if (fifo_push) begin
				tail_q <= tail_q + 1'b1;
			end
			if (fifo_pop) begin
				head_q <= head_q + 1'b1;
			end
			cnt_q  <= cnt_q + CNT_W'(fifo_push) - CNT_W'(fifo_pop);
			pend_q <= pend_q + CNT_W'(accept && col_end) - CNT_W'(fifo_pop);
		end
	end

	assign result_ch.valid      = (cnt_q != '0);
	assign result_ch.row_result = fifo_q[head_q].row_result;
	assign result_ch.row_index  = fifo_q[head_q].row_index;
	assign result_ch.last_row   = fifo_q[head_q].last_row;

	`AVI_ASSERT_IMPL(a_fifo_no_overflow, clk, arst_n, fifo_push && !fifo_pop, cnt_q < CNT_W'(FIFO_DEPTH))
	`AVI_ASSERT_IMPL(a_pend_covers_queue, clk, arst_n, 1'b1, pend_q <= CNT_W'(FIFO_DEPTH) && cnt_q <= pend_q)
	`AVI_ASSERT_IMPL(a_no_read_of_pending_write, clk, arst_n, accept, !(v_s3 && (wbank_s3 == sel_q)))
	`AVI_ASSERT_IMPL(a_last_row_index, clk, arst_n, result_ch.valid && result_ch.last_row, result_ch.row_index == ROW_IDX_W'(VECTOR_SIZE - 1))

endmodule
